/* sv/ccs_pkg.sv */
// Shared types and constants for the CSV cell splitter.
package ccs_pkg;

    localparam int RUN_DEPTH = 4;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    localparam logic [23:0] PREFIX_SUM = 24'h53554D;
    localparam logic [23:0] PREFIX_AVG = 24'h415647;
    localparam logic [23:0] PREFIX_MAX = 24'h4D4158;
    localparam logic [23:0] PREFIX_MIN = 24'h4D494E;

    localparam logic [10:0] MAX_COLUMNS_RST     = 11'd1000;
    localparam logic [15:0] MAX_LINES_RST       = 16'd10000;
    localparam logic [15:0] MAX_LINE_LENGTH_RST = 16'd10000;

    localparam logic [1:0] REG_MAX_COLUMNS     = 2'd0;
    localparam logic [1:0] REG_MAX_LINES       = 2'd1;
    localparam logic [1:0] REG_MAX_LINE_LENGTH = 2'd2;

    localparam logic [16:0] SAT17    = 17'h1FFFF;
    localparam logic [15:0] SAT16    = 16'hFFFF;
    localparam logic [2:0]  PREFIX_LEN = 3'd3;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_CELL_END = 2'd1,
        KIND_ROW_END  = 2'd2,
        KIND_DATA_END = 2'd3
    } ccs_kind_t;

    typedef struct packed {
        ccs_kind_t   kind;
        logic [7:0]  byte_value;
        logic [9:0]  column;
        logic [15:0] row;
        logic        invalid;
    } ccs_result_t;

    typedef struct packed {
        logic [2:0]                    count;
        ccs_result_t [RUN_DEPTH-1:0]   res;
    } ccs_bundle_t;

    typedef struct packed {
        logic [10:0] cell_index;
        logic [15:0] rows_emitted;
        logic [16:0] lines_seen;
        logic [16:0] line_length;
        logic        line_nonempty;
        logic        cell_open;
        logic        line_limit_hit;
        logic        equals_seen;
        logic [2:0]  bytes_after_equals;
        logic [23:0] formula_prefix;
        logic        stream_invalid;
    } ccs_state_t;

endpackage

/* sv/ccs_core.sv */
// Per-byte tokenizer logic and stream state registers.
module ccs_core
    import ccs_pkg::*;
#(
    parameter int COLUMN_LIMIT_MAX = 1024,
    parameter int LINE_LIMIT_MAX   = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    input  logic [10:0] max_columns,
    input  logic [15:0] max_lines,
    input  logic [15:0] max_line_length,
    output ccs_bundle_t bundle
);

    localparam logic [10:0] COL_CAP  =
        (COLUMN_LIMIT_MAX > 2047) ? 11'h7FF : 11'(COLUMN_LIMIT_MAX);
    localparam logic [15:0] LINE_CAP =
        (LINE_LIMIT_MAX > 65535) ? 16'hFFFF : 16'(LINE_LIMIT_MAX);

    ccs_state_t state_reg;
    ccs_state_t state_next;

    logic [10:0] eff_cols;
    logic [15:0] eff_lines;

    assign eff_cols  = (max_columns > COL_CAP) ? COL_CAP : max_columns;
    assign eff_lines = (max_lines > LINE_CAP) ? LINE_CAP : max_lines;

    always_comb
    begin
        ccs_state_t                  st;
        ccs_result_t [RUN_DEPTH-1:0] res;
        logic [2:0]                  n;
        logic                        parsed;
        logic [7:0]                  upper;

        st     = state_reg;
        res    = '0;
        n      = 3'd0;
        parsed = state_reg.lines_seen < {1'b0, eff_lines};
        upper  = (data_byte >= CH_LOWER_A && data_byte <= CH_LOWER_Z)
                 ? data_byte - CASE_DELTA : data_byte;

        // Formula check: only the first '=' of the stream arms it.
        if (!st.equals_seen)
        begin
            if (data_byte == CH_EQUALS)
                st.equals_seen = 1'b1;
        end
        else if (st.bytes_after_equals < PREFIX_LEN)
        begin
            st.formula_prefix     = {st.formula_prefix[15:0], upper};
            st.bytes_after_equals = st.bytes_after_equals + 3'd1;
        end
        else if (st.bytes_after_equals == PREFIX_LEN)
        begin
            st.bytes_after_equals = PREFIX_LEN + 3'd1;
            if (st.formula_prefix == PREFIX_SUM || st.formula_prefix == PREFIX_AVG ||
                st.formula_prefix == PREFIX_MAX || st.formula_prefix == PREFIX_MIN)
                st.stream_invalid = 1'b1;
        end

        if (data_byte != CH_NEWLINE)
        begin
            if (st.line_length != SAT17)
                st.line_length = st.line_length + 17'd1;
            if (st.line_length > {1'b0, max_line_length})
                st.line_limit_hit = 1'b1;
            if (parsed && st.cell_index < eff_cols)
            begin
                res[n[1:0]].kind       = (data_byte == CH_COMMA) ? KIND_CELL_END
                                                                 : KIND_BYTE;
                res[n[1:0]].byte_value = (data_byte == CH_COMMA) ? 8'd0 : data_byte;
                res[n[1:0]].column     = st.cell_index[9:0];
                res[n[1:0]].row        = st.rows_emitted;
                res[n[1:0]].invalid    = 1'b0;
                n                      = n + 3'd1;
                st.line_nonempty       = 1'b1;
                if (data_byte == CH_COMMA)
                begin
                    st.cell_open  = 1'b0;
                    st.cell_index = st.cell_index + 11'd1;
                end
                else
                begin
                    st.cell_open = 1'b1;
                end
            end
        end

        // Close the line on newline, or on the final byte of the stream.
        if (data_byte == CH_NEWLINE || end_of_data)
        begin
            if (parsed)
            begin
                if (st.cell_open)
                begin
                    res[n[1:0]].kind       = KIND_CELL_END;
                    res[n[1:0]].byte_value = 8'd0;
                    res[n[1:0]].column     = st.cell_index[9:0];
                    res[n[1:0]].row        = st.rows_emitted;
                    res[n[1:0]].invalid    = 1'b0;
                    n                      = n + 3'd1;
                end
                if (st.line_nonempty)
                begin
                    res[n[1:0]].kind       = KIND_ROW_END;
                    res[n[1:0]].byte_value = 8'd0;
                    res[n[1:0]].column     = 10'd0;
                    res[n[1:0]].row        = st.rows_emitted;
                    res[n[1:0]].invalid    = 1'b0;
                    n                      = n + 3'd1;
                    if (st.rows_emitted != SAT16)
                        st.rows_emitted = st.rows_emitted + 16'd1;
                end
            end
            if (st.lines_seen != SAT17)
                st.lines_seen = st.lines_seen + 17'd1;
            st.cell_index    = 11'd0;
            st.line_length   = 17'd0;
            st.cell_open     = 1'b0;
            st.line_nonempty = 1'b0;
        end

        if (end_of_data)
        begin
            res[n[1:0]].kind       = KIND_DATA_END;
            res[n[1:0]].byte_value = 8'd0;
            res[n[1:0]].column     = 10'd0;
            res[n[1:0]].row        = st.rows_emitted;
            res[n[1:0]].invalid    = st.line_limit_hit | st.stream_invalid;
            n                      = n + 3'd1;
            st                     = '0;
        end

        bundle.count = n;
        bundle.res   = res;
        state_next   = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step)
            state_reg <= state_next;
    end

endmodule

/* sv/ccs_run_buf.sv */
// Result buffer that holds the results of one byte and drains them in order.
module ccs_run_buf
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  ccs_bundle_t bundle,
    input  logic        out_ready,
    output logic        can_load,
    output logic        out_valid,
    output ccs_result_t head,
    output logic        last_of_run
);

    ccs_result_t run_reg  [RUN_DEPTH];
    ccs_result_t run_next [RUN_DEPTH];
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        drain;

    assign out_valid   = (cnt_reg != 3'd0);
    assign drain       = out_valid && out_ready;
    assign can_load    = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && out_ready);
    assign head        = run_reg[0];
    assign last_of_run = (cnt_reg == 3'd1);

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            for (int i = 0; i < RUN_DEPTH; i++)
                run_next[i] = bundle.res[i];
            cnt_next = bundle.count;
        end
        else if (drain)
        begin
            // Advance the queue by one entry.
            for (int i = 0; i < RUN_DEPTH - 1; i++)
                run_next[i] = run_reg[i+1];
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

endmodule

/* sv/csv_cell_splitter.sv */
// Top level of the CSV cell splitter: config registers, input stage, core, result buffer.
// Flow: an accepted byte is held in the input register until the result buffer can take
//   its whole run; the run is then loaded into the buffer and offered head first.
// Throughput: one byte per cycle while out_ready is high and each byte gives at most one
//   result; a byte that gives k results holds the output port for k transfers (k <= 4).
// Reset: rst_n clears all stream state and restores max_columns 1000, max_lines 10000,
//   max_line_length 10000. End of data also returns stream state to reset.
module csv_cell_splitter
    import ccs_pkg::*;
#(
    parameter int COLUMN_LIMIT_MAX = 1024,
    parameter int LINE_LIMIT_MAX   = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  byte_value,
    output logic [9:0]  column,
    output logic [15:0] row,
    output logic        last_of_run,
    output logic        invalid
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; reads are
    // a plain mux on the register index (word address).
    // ------------------------------------------------------------------
    logic [10:0] max_columns_reg;
    logic [15:0] max_lines_reg;
    logic [15:0] max_line_length_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_columns_reg     <= MAX_COLUMNS_RST;
            max_lines_reg       <= MAX_LINES_RST;
            max_line_length_reg <= MAX_LINE_LENGTH_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MAX_COLUMNS:     max_columns_reg     <= pwdata[10:0];
                REG_MAX_LINES:       max_lines_reg       <= pwdata[15:0];
                REG_MAX_LINE_LENGTH: max_line_length_reg <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_COLUMNS:     prdata = {21'd0, max_columns_reg};
            REG_MAX_LINES:       prdata = {16'd0, max_lines_reg};
            REG_MAX_LINE_LENGTH: prdata = {16'd0, max_line_length_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register. Hold one byte; it is consumed when the result
    // buffer can take the whole run that the byte produces. A new byte
    // transfers in the same cycle that the held one is consumed.
    // ------------------------------------------------------------------
    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       in_eod_reg;
    logic       can_load;
    logic       step;
    logic       in_xfer;

    assign step     = in_full_reg && can_load;
    assign in_ready = !in_full_reg || step;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_xfer)
            in_full_reg <= 1'b1;
        else if (step)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= data_byte;
            in_eod_reg  <= end_of_data;
        end
    end

    // ------------------------------------------------------------------
    // Tokenizer core: turns the held byte and the stream state into up to
    // four results and advances the state when the run is loaded.
    // ------------------------------------------------------------------
    ccs_bundle_t bundle;

    ccs_core #(
        .COLUMN_LIMIT_MAX (COLUMN_LIMIT_MAX),
        .LINE_LIMIT_MAX   (LINE_LIMIT_MAX)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (in_byte_reg),
        .end_of_data     (in_eod_reg),
        .max_columns     (max_columns_reg),
        .max_lines       (max_lines_reg),
        .max_line_length (max_line_length_reg),
        .bundle          (bundle)
    );

    // ------------------------------------------------------------------
    // Result buffer: one transfer per result, in order; last_of_run marks
    // the final result of a byte's run.
    // ------------------------------------------------------------------
    ccs_result_t head;

    ccs_run_buf u_run_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .bundle      (bundle),
        .out_ready   (out_ready),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .head        (head),
        .last_of_run (last_of_run)
    );

    assign kind       = head.kind;
    assign byte_value = head.byte_value;
    assign column     = head.column;
    assign row        = head.row;
    assign invalid    = head.invalid;

endmodule

/* sv/ccs_checker.sv */
// Port-level checker for the CSV cell splitter, bound to the top level.
module ccs_checker
    import ccs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  byte_value,
    input logic [9:0]  column,
    input logic [15:0] row,
    input logic        last_of_run,
    input logic        invalid
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({kind, byte_value, column, row, last_of_run, invalid}))
        else $error("result changed while stalled");

    a_byte_only_on_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> byte_value == 8'd0)
        else $error("byte value on a non-byte result");

    a_data_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DATA_END |-> last_of_run && column == 10'd0)
        else $error("end of data is not last of its run");

    a_row_end_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ROW_END |-> column == 10'd0)
        else $error("row end with nonzero column");

    a_invalid_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> kind == KIND_DATA_END)
        else $error("invalid flag outside end of data");

endmodule

bind csv_cell_splitter ccs_checker u_ccs_checker (.*);

/* test/csv_cell_splitter_tb.sv */
// Self-checking testbench for csv_cell_splitter: directed and random byte streams, scoreboard.
module csv_cell_splitter_tb;
    import ccs_pkg::*;

    localparam int COL_LIMIT   = 1024;
    localparam int LINE_LIMIT  = 65535;
    localparam int CYCLE_LIMIT = 200000;

    // One byte of the text stream as the sender offers it.
    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } stream_byte_t;

    // One token as the block should emit it.
    typedef struct packed {
        ccs_kind_t   kind;
        logic [7:0]  byte_value;
        logic [9:0]  column;
        logic [15:0] row;
        logic        last_of_run;
        logic        invalid;
    } token_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte   = 8'd0;
    logic        end_of_data = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [9:0]  column;
    logic [15:0] row;
    logic        last_of_run;
    logic        invalid;

    csv_cell_splitter #(
        .COLUMN_LIMIT_MAX (COL_LIMIT),
        .LINE_LIMIT_MAX   (LINE_LIMIT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .byte_value  (byte_value),
        .column      (column),
        .row         (row),
        .last_of_run (last_of_run),
        .invalid     (invalid)
    );

    // Bytes waiting for the sender, and tokens waiting for the block to emit them.
    stream_byte_t pending_bytes[$];
    token_t       token_q[$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int err_count  = 0;
    int cycle_count = 0;

    // Sender burst shaping.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall pattern; the long hold is requested once by the stimulus.
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;
    bit rx_hold_req  = 1'b0;
    bit rx_hold_done = 1'b0;

    // Predictor copy of the registers.
    logic [10:0] cfg_cols  = MAX_COLUMNS_RST;
    logic [15:0] cfg_lines = MAX_LINES_RST;
    logic [15:0] cfg_len   = MAX_LINE_LENGTH_RST;

    // Predictor copy of the stream state.
    logic [10:0] cell_idx      = '0;
    logic [15:0] rows_out      = '0;
    logic [16:0] lines_cnt     = '0;
    logic [16:0] line_len      = '0;
    bit          line_has_cell = 1'b0;
    bit          cell_has_byte = 1'b0;
    bit          len_exceeded  = 1'b0;
    bit          eq_seen       = 1'b0;
    logic [2:0]  eq_count      = '0;
    logic [23:0] prefix        = '0;
    bit          formula_bad   = 1'b0;

    //------------------------------------------------------------------
    // Clock and cycle limit
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d tokens outstanding",
                     cycle_count, token_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Error reporting
    //------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %0h expected %0h",
                                 n_results, name, got, want));
    endtask

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic bit lines_allowed();
        int limit;
        limit = (int'(cfg_lines) > LINE_LIMIT) ? LINE_LIMIT : int'(cfg_lines);
        return int'(lines_cnt) < limit;
    endfunction

    task automatic push_token(input ccs_kind_t k, input logic [7:0] b,
                              input logic [9:0] col, input logic [15:0] r,
                              input logic inv);
        token_t t;
        t.kind        = k;
        t.byte_value  = b;
        t.column      = col;
        t.row         = r;
        t.last_of_run = 1'b0;
        t.invalid     = inv;
        token_q = {token_q, t};
    endtask

    // Close the current line: flush an open cell, then a row if it held any cell.
    task automatic close_line();
        if (lines_allowed())
        begin
            if (cell_has_byte)
                push_token(KIND_CELL_END, 8'd0, cell_idx[9:0], rows_out, 1'b0);
            if (line_has_cell)
            begin
                push_token(KIND_ROW_END, 8'd0, 10'd0, rows_out, 1'b0);
                if (rows_out != SAT16)
                    rows_out++;
            end
        end
        if (lines_cnt != SAT17)
            lines_cnt++;
        cell_idx      = '0;
        line_len      = '0;
        cell_has_byte = 1'b0;
        line_has_cell = 1'b0;
    endtask

    task automatic restart_stream();
        cell_idx      = '0;
        rows_out      = '0;
        lines_cnt     = '0;
        line_len      = '0;
        line_has_cell = 1'b0;
        cell_has_byte = 1'b0;
        len_exceeded  = 1'b0;
        eq_seen       = 1'b0;
        eq_count      = '0;
        prefix        = '0;
        formula_bad   = 1'b0;
    endtask

    // Work out every token that one accepted byte causes and queue them in order.
    task automatic tokenize_byte(input logic [7:0] b, input logic eod);
        int          first;
        int          eff_cols;
        bit          parsed;
        logic [7:0]  up;
        token_t      t;
        first    = token_q.size();
        eff_cols = (int'(cfg_cols) > COL_LIMIT) ? COL_LIMIT : int'(cfg_cols);
        parsed   = lines_allowed();

        // Formula check: only the first '=' of the stream arms it, and the
        // verdict falls on the fourth byte after it, across cells and lines.
        if (!eq_seen)
        begin
            if (b == CH_EQUALS)
                eq_seen = 1'b1;
        end
        else if (eq_count < PREFIX_LEN)
        begin
            up       = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_DELTA : b;
            prefix   = {prefix[15:0], up};
            eq_count = eq_count + 3'd1;
        end
        else if (eq_count == PREFIX_LEN)
        begin
            eq_count = 3'd4;
            if (prefix == PREFIX_SUM || prefix == PREFIX_AVG ||
                prefix == PREFIX_MAX || prefix == PREFIX_MIN)
                formula_bad = 1'b1;
        end

        if (b == CH_NEWLINE)
            close_line();
        else
        begin
            if (line_len != SAT17)
                line_len++;
            if (line_len > {1'b0, cfg_len})
                len_exceeded = 1'b1;
            if (parsed && int'(cell_idx) < eff_cols)
            begin
                if (b == CH_COMMA)
                begin
                    push_token(KIND_CELL_END, 8'd0, cell_idx[9:0], rows_out, 1'b0);
                    line_has_cell = 1'b1;
                    cell_has_byte = 1'b0;
                    cell_idx++;
                end
                else
                begin
                    push_token(KIND_BYTE, b, cell_idx[9:0], rows_out, 1'b0);
                    line_has_cell = 1'b1;
                    cell_has_byte = 1'b1;
                end
            end
        end

        // End of data closes an unterminated final line and reports the verdict.
        if (eod)
        begin
            if (b != CH_NEWLINE && line_len != 0)
                close_line();
            push_token(KIND_DATA_END, 8'd0, 10'd0, rows_out, len_exceeded || formula_bad);
            restart_stream();
        end

        // Mark the last token of this byte's run.
        if (token_q.size() > first)
        begin
            t = token_q[token_q.size() - 1];
            t.last_of_run = 1'b1;
            token_q[token_q.size() - 1] = t;
        end
    endtask

    //------------------------------------------------------------------
    // Driver: offer queued bytes in bursts with random gaps
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        logic         next_valid;
        stream_byte_t item;
        next_valid = in_valid;
        // A transfer happened at this edge: predict it, then drop valid.
        if (in_valid && in_ready)
        begin
            tokenize_byte(data_byte, end_of_data);
            n_accepted++;
            next_valid = 1'b0;
        end
        // Hold an unaccepted byte; otherwise advance to the next one after the gap.
        if (!next_valid && rst_n)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_bytes.size() > 0)
            begin
                item        = pending_bytes.pop_front();
                data_byte   <= item.data;
                end_of_data <= item.eod;
                next_valid  = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        in_valid <= next_valid;
    end

    //------------------------------------------------------------------
    // Receiver: ready pattern of its own plus one long hold-off
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        logic rdy;
        rdy = 1'b1;
        if (rx_hold_req && !rx_hold_done)
        begin
            rx_hold_left = 250;
            rx_hold_done = 1'b1;
        end
        if (rx_hold_left > 0)
        begin
            // Hold off long enough for the block to fill and stall its input.
            rx_hold_left--;
            rdy = 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(10, 60);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = ($urandom_range(0, 3) == 0);
                default: rdy = ~out_ready;
            endcase
        end
        out_ready <= rdy;
    end

    //------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest queued token
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        token_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (token_q.size() == 0)
                flag_error($sformatf("result %0d with nothing pending: kind %0d row %0d",
                                     n_results, kind, row));
            else
            begin
                want = token_q.pop_front();
                check_field("kind",        {14'd0, kind},        {14'd0, want.kind});
                check_field("byte_value",  {8'd0, byte_value},   {8'd0, want.byte_value});
                check_field("column",      {6'd0, column},       {6'd0, want.column});
                check_field("row",         row,                  want.row);
                check_field("last_of_run", {15'd0, last_of_run}, {15'd0, want.last_of_run});
                check_field("invalid",     {15'd0, invalid},     {15'd0, want.invalid});
            end
            n_results++;
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    task automatic push_item(input logic [7:0] b, input logic eod);
        stream_byte_t item;
        item.data = b;
        item.eod  = eod;
        pending_bytes = {pending_bytes, item};
        n_queued++;
    endtask

    task automatic push_text(input string s, input bit eod_last);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], eod_last && (i == s.len() - 1));
    endtask

    // Register write over the config port: setup cycle, then access cycle.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_COLUMNS:     cfg_cols  = value[10:0];
            REG_MAX_LINES:       cfg_lines = value[15:0];
            REG_MAX_LINE_LENGTH: cfg_len   = value[15:0];
            default: ;
        endcase
    endtask

    // Wait for every queued byte to transfer and every token to arrive, then
    // let the pipeline settle.
    task automatic drain();
        while (n_accepted != n_queued)
            @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Random cell character, letters in either case.
    function automatic logic [7:0] cell_char();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            c = 8'h41 + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1))
                c = c + CASE_DELTA;
        end
        else if (pick < 9)
            c = 8'h30 + 8'($urandom_range(0, 9));
        else
            c = 8'($urandom_range(32, 126));
        return c;
    endfunction

    // Build one well-formed stream: a few lines of short cells, sometimes
    // with a formula, empty lines and trailing commas, ending in end of data.
    task automatic build_stream();
        logic [7:0] buf_q[$];
        string      names[5];
        string      nm;
        logic [7:0] c;
        int         n_lines;
        int         n_cells;
        names[0] = "SUM";
        names[1] = "AVG";
        names[2] = "MAX";
        names[3] = "MIN";
        names[4] = "SUX";
        n_lines  = $urandom_range(1, 3);
        for (int l = 0; l < n_lines; l++)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                n_cells = $urandom_range(1, 3);
                for (int k = 0; k < n_cells; k++)
                begin
                    if (k > 0)
                        buf_q = {buf_q, CH_COMMA};
                    if ($urandom_range(0, 7) == 0)
                    begin
                        buf_q = {buf_q, CH_EQUALS};
                        nm = names[$urandom_range(0, 4)];
                        for (int j = 0; j < 3; j++)
                        begin
                            c = nm[j];
                            if ($urandom_range(0, 1))
                                c = c + CASE_DELTA;
                            buf_q = {buf_q, c};
                        end
                    end
                    repeat ($urandom_range(0, 3))
                        buf_q = {buf_q, cell_char()};
                end
                if ($urandom_range(0, 5) == 0)
                    buf_q = {buf_q, CH_COMMA};
            end
            buf_q = {buf_q, CH_NEWLINE};
        end
        // Drop the final newline half the time so end of data closes the line.
        if (buf_q.size() > 1 && $urandom_range(0, 1))
            void'(buf_q.pop_back());
        for (int i = 0; i < buf_q.size(); i++)
            push_item(buf_q[i], i == buf_q.size() - 1);
    endtask

    task automatic gen_traffic(input int budget);
        int start;
        start = n_queued;
        while (n_queued - start < budget)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // Noise: arbitrary bytes, end of data now and then.
                repeat ($urandom_range(1, 6))
                    push_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            else
                build_stream();
        end
    endtask

    task automatic run_phase(input int cols, input int lines, input int len,
                             input int budget, input bit hold_rx);
        cfg_write(REG_MAX_COLUMNS, cols);
        cfg_write(REG_MAX_LINES, lines);
        cfg_write(REG_MAX_LINE_LENGTH, len);
        gen_traffic(budget);
        if (hold_rx)
            rx_hold_req = 1'b1;
        drain();
    endtask

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed streams under the reset register values.
        push_text("ab,c\n", 1'b0);
        push_text("\n", 1'b0);                 // empty line gives no row
        push_text(",,\n", 1'b0);               // cells with no bytes
        push_text("x,", 1'b1);                 // trailing comma, unterminated line
        push_text("=sUm,q", 1'b1);             // formula prefix in mixed case
        push_text("=MAX", 1'b1);               // prefix with no fourth byte
        push_text("hi\n", 1'b1);               // newline as final byte
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        drain();

        // Random streams over a range of register settings, extremes included.
        run_phase(2, 3, 6, 24, 1'b1);
        run_phase(1, 1, 1, 20, 1'b0);
        run_phase(0, 0, 0, 16, 1'b0);
        run_phase(2047, 65535, 65535, 20, 1'b0);
        run_phase(1024, 2, 3, 20, 1'b0);
        run_phase(3, 65535, 0, 20, 1'b0);
        run_phase($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 12),
                  18, 1'b0);
        run_phase($urandom_range(0, 2047), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), 18, 1'b0);

        repeat (20) @(posedge clk);
        if (token_q.size() != 0)
            flag_error($sformatf("%0d tokens never arrived", token_q.size()));
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* csv_cell_splitter.f */
sv/ccs_pkg.sv
sv/ccs_core.sv
sv/ccs_run_buf.sv
sv/csv_cell_splitter.sv
sv/ccs_checker.sv
test/csv_cell_splitter_tb.sv
